// ----- sv/tpsi_pkg.sv -----
// Shared constants, codes and types for the tensor pad source index block.
// No dependencies; the RTL files refer to this package by scoped names, the testbench imports it.
package tpsi_pkg;

	localparam int DIM_BITS    = 12;
	localparam int TENSOR_RANK = 4;
	localparam int COORD_W     = 13;
	localparam int OFFSET_W    = 48;
	localparam int FILL_W      = 32;
	localparam int CFG_DATA_W  = 32;
	localparam int CFG_IDX_W   = 3;
	localparam int GEO_PAD_LSB = 16;

	// signed working width for one dimension: covers 2*size + pad - coord
	localparam int MAP_SW = ((COORD_W > DIM_BITS + 1) ? COORD_W : DIM_BITS + 1) + 2;

	// partial offset widths, index of each dimension is below its size
	localparam int P1_W = 2 * DIM_BITS;
	localparam int P2_W = 3 * DIM_BITS;
	localparam int P3_W = 4 * DIM_BITS;

	localparam logic signed [MAP_SW-1:0] ADJ_ZERO = '0;
	localparam logic signed [MAP_SW-1:0] ADJ_M1   = -MAP_SW'(1);
	localparam logic signed [MAP_SW-1:0] ADJ_M2   = -MAP_SW'(2);

	typedef enum logic [1:0] {
		MODE_CONSTANT    = 2'd0,
		MODE_REFLECT     = 2'd1,
		MODE_SYMMETRIC   = 2'd2,
		MODE_UNSUPPORTED = 2'd3
	} pad_mode_t;

	localparam logic [CFG_IDX_W-1:0] REG_PAD_MODE    = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_FILL_BITS   = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_BATCH_GEO   = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_CHANNEL_GEO = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_HEIGHT_GEO  = 3'd4;
	localparam logic [CFG_IDX_W-1:0] REG_WIDTH_GEO   = 3'd5;

	localparam logic [1:0] DIM_BATCH   = 2'd0;
	localparam logic [1:0] DIM_CHANNEL = 2'd1;
	localparam logic [1:0] DIM_HEIGHT  = 2'd2;
	localparam logic [1:0] DIM_WIDTH   = 2'd3;

	typedef struct packed {
		logic [DIM_BITS-1:0] idx;
		logic                fill;
		logic                err;
	} dim_map_t;

endpackage

// ----- sv/tpsi_ifs.sv -----
// Handshake interfaces: coordinate items in, address items out, config writes.
// Depends on tpsi_pkg for field widths.
interface tpsi_coord_if;
	logic                         valid;
	logic                         ready;
	logic [tpsi_pkg::COORD_W-1:0] out_batch;
	logic [tpsi_pkg::COORD_W-1:0] out_channel;
	logic [tpsi_pkg::COORD_W-1:0] out_row;
	logic [tpsi_pkg::COORD_W-1:0] out_column;

	modport source (output valid, output out_batch, output out_channel,
		output out_row, output out_column, input ready);
	modport sink (input valid, input out_batch, input out_channel,
		input out_row, input out_column, output ready);
endinterface

interface tpsi_addr_if;
	logic                          valid;
	logic                          ready;
	logic [tpsi_pkg::OFFSET_W-1:0] source_offset;
	logic                          use_fill;
	logic [tpsi_pkg::FILL_W-1:0]   fill_word;
	logic                          index_error;

	modport source (output valid, output source_offset, output use_fill,
		output fill_word, output index_error, input ready);
	modport sink (input valid, input source_offset, input use_fill,
		input fill_word, input index_error, output ready);
endinterface

interface tpsi_cfg_if;
	logic                            valid;
	logic                            ready;
	logic [tpsi_pkg::CFG_IDX_W-1:0]  index;
	logic [tpsi_pkg::CFG_DATA_W-1:0] data;

	modport source (output valid, output index, output data, input ready);
	modport sink (input valid, input index, input data, output ready);
endinterface

// ----- sv/tpsi_dim_map.sv -----
// Maps one padded-output coordinate to an input index for one dimension.
// Depends on tpsi_pkg (mode codes, widths, dim_map_t).
module tpsi_dim_map (
	input  tpsi_pkg::pad_mode_t                mode,
	input  logic [tpsi_pkg::COORD_W-1:0]       coord,
	input  logic [tpsi_pkg::DIM_BITS-1:0]      size,
	input  logic [tpsi_pkg::DIM_BITS-1:0]      pad,
	output tpsi_pkg::dim_map_t                 map
);

	logic signed [tpsi_pkg::MAP_SW-1:0] o_s;
	logic signed [tpsi_pkg::MAP_SW-1:0] s_s;
	logic signed [tpsi_pkg::MAP_SW-1:0] p_s;
	logic signed [tpsi_pkg::MAP_SW-1:0] lead;
	logic signed [tpsi_pkg::MAP_SW-1:0] past;
	logic signed [tpsi_pkg::MAP_SW-1:0] direct;
	logic signed [tpsi_pkg::MAP_SW-1:0] left_adj;
	logic signed [tpsi_pkg::MAP_SW-1:0] right_adj;
	logic signed [tpsi_pkg::MAP_SW-1:0] mirrored;
	logic signed [tpsi_pkg::MAP_SW-1:0] sel;
	logic                               outside;

	assign o_s    = tpsi_pkg::MAP_SW'(coord);
	assign s_s    = tpsi_pkg::MAP_SW'(size);
	assign p_s    = tpsi_pkg::MAP_SW'(pad);
	assign lead   = p_s - o_s;
	assign past   = o_s - (s_s + p_s);
	assign direct = o_s - p_s;

	// reflect skips the edge element, symmetric repeats it
	assign left_adj  = (mode == tpsi_pkg::MODE_REFLECT) ? tpsi_pkg::ADJ_ZERO : tpsi_pkg::ADJ_M1;
	assign right_adj = (mode == tpsi_pkg::MODE_REFLECT) ? tpsi_pkg::ADJ_M2 : tpsi_pkg::ADJ_M1;

	always_comb begin
		priority if (lead > tpsi_pkg::ADJ_ZERO) begin
			mirrored = lead + left_adj;
		end else if (past >= tpsi_pkg::ADJ_ZERO) begin
			mirrored = s_s - past + right_adj;
		end else begin
			mirrored = direct;
		end
	end

	assign sel     = (mode == tpsi_pkg::MODE_CONSTANT) ? direct : mirrored;
	assign outside = (sel < tpsi_pkg::ADJ_ZERO) || (sel >= s_s);

	always_comb begin
		map.idx  = outside ? '0 : sel[tpsi_pkg::DIM_BITS-1:0];
		map.fill = outside && (mode == tpsi_pkg::MODE_CONSTANT);
		map.err  = outside && (mode != tpsi_pkg::MODE_CONSTANT);
	end

endmodule

// ----- sv/tensor_pad_source_index.sv -----
// Top level of the tensor pad source index block: config registers, pipeline.
// Depends on tpsi_pkg, tpsi_ifs (interfaces) and tpsi_dim_map.
//
// Usage:
//   coord : one item per padded-output NCHW coordinate (batch, channel, row,
//           column), accepted when valid and ready are both high.
//   addr  : one item per coordinate, in order: flat source offset into the
//           unpadded input, or use_fill with the fill word, or index_error.
//   cfg   : register writes (index 0 pad mode, 1 fill bits, 2..5 geometry of
//           batch, channel, height, width). Always ready; write only while
//           no item is in flight.
// Four register stages; addr valid is the fourth stage's valid bit. One item
// per cycle sustained while addr is ready. Stages: dimension mapping, then one
// multiply-add per stage for b*C+c, *H+h, *W+w; the last lands in the output
// register.
// A stalled addr side holds the output register; ready propagates back
// stage by stage, so bubbles are squeezed out and no item is lost.
// Reset clears all valid bits and loads mode constant, fill 0, and every
// dimension as size 1 with no padding.
module tensor_pad_source_index (
	input  logic                 clk,
	input  logic                 arst_n,
	tpsi_coord_if.sink           coord,
	tpsi_addr_if.source          addr,
	tpsi_cfg_if.sink             cfg
);

	localparam int D = tpsi_pkg::DIM_BITS;
	localparam int R = tpsi_pkg::TENSOR_RANK;

	// configuration
	tpsi_pkg::pad_mode_t        mode_q;
	logic [tpsi_pkg::FILL_W-1:0] fill_q;
	logic [D-1:0]               size_q [R];
	logic [D-1:0]               pad_q  [R];

	assign cfg.ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q <= tpsi_pkg::MODE_CONSTANT;
			fill_q <= '0;
			for (int i = 0; i < R; i++) begin
				size_q[i] <= D'(1);
				pad_q[i]  <= '0;
			end
		end else if (cfg.valid) begin
			unique case (cfg.index)
				tpsi_pkg::REG_PAD_MODE: begin
					mode_q <= tpsi_pkg::pad_mode_t'(cfg.data[1:0]);
				end
				tpsi_pkg::REG_FILL_BITS: begin
					fill_q <= cfg.data[tpsi_pkg::FILL_W-1:0];
				end
				tpsi_pkg::REG_BATCH_GEO: begin
					size_q[tpsi_pkg::DIM_BATCH] <= cfg.data[D-1:0];
					pad_q[tpsi_pkg::DIM_BATCH]  <= cfg.data[tpsi_pkg::GEO_PAD_LSB +: D];
				end
				tpsi_pkg::REG_CHANNEL_GEO: begin
					size_q[tpsi_pkg::DIM_CHANNEL] <= cfg.data[D-1:0];
					pad_q[tpsi_pkg::DIM_CHANNEL]  <= cfg.data[tpsi_pkg::GEO_PAD_LSB +: D];
				end
				tpsi_pkg::REG_HEIGHT_GEO: begin
					size_q[tpsi_pkg::DIM_HEIGHT] <= cfg.data[D-1:0];
					pad_q[tpsi_pkg::DIM_HEIGHT]  <= cfg.data[tpsi_pkg::GEO_PAD_LSB +: D];
				end
				tpsi_pkg::REG_WIDTH_GEO: begin
					size_q[tpsi_pkg::DIM_WIDTH] <= cfg.data[D-1:0];
					pad_q[tpsi_pkg::DIM_WIDTH]  <= cfg.data[tpsi_pkg::GEO_PAD_LSB +: D];
				end
				default: begin
					// indexes past the register list are dropped
				end
			endcase
		end
	end

	// per-dimension mapping (feeds stage 1)
	logic [tpsi_pkg::COORD_W-1:0] coord_a [R];
	tpsi_pkg::dim_map_t           map_a   [R];
	logic [R-1:0]                 fill_v;
	logic [R-1:0]                 err_v;

	assign coord_a[tpsi_pkg::DIM_BATCH]   = coord.out_batch;
	assign coord_a[tpsi_pkg::DIM_CHANNEL] = coord.out_channel;
	assign coord_a[tpsi_pkg::DIM_HEIGHT]  = coord.out_row;
	assign coord_a[tpsi_pkg::DIM_WIDTH]   = coord.out_column;

	for (genvar g = 0; g < R; g++) begin : g_dim
		tpsi_dim_map u_map (
			.mode  (mode_q),
			.coord (coord_a[g]),
			.size  (size_q[g]),
			.pad   (pad_q[g]),
			.map   (map_a[g])
		);
		assign fill_v[g] = map_a[g].fill;
		assign err_v[g]  = map_a[g].err;
	end

	// handshake chain: a stage loads when empty or when its successor moves
	logic v_s1, v_s2, v_s3, v_s4;
	logic rdy_s1, rdy_s2, rdy_s3, rdy_s4;

	assign rdy_s4     = !v_s4 || addr.ready;
	assign rdy_s3     = !v_s3 || rdy_s4;
	assign rdy_s2     = !v_s2 || rdy_s3;
	assign rdy_s1     = !v_s1 || rdy_s2;
	assign coord.ready = rdy_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
		end else begin
			if (rdy_s1) begin
				v_s1 <= coord.valid;
			end
			if (rdy_s2) begin
				v_s2 <= v_s1;
			end
			if (rdy_s3) begin
				v_s3 <= v_s2;
			end
			if (rdy_s4) begin
				v_s4 <= v_s3;
			end
		end
	end

	// payload
	logic [D-1:0]                  idx_s1 [R];
	logic                          fill_s1, err_s1;
	logic [tpsi_pkg::P1_W-1:0]     p1_s2;
	logic [D-1:0]                  row_s2, col_s2;
	logic                          fill_s2, err_s2;
	logic [tpsi_pkg::P2_W-1:0]     p2_s3;
	logic [D-1:0]                  col_s3;
	logic                          fill_s3, err_s3;
	logic [tpsi_pkg::OFFSET_W-1:0] offset_s4;
	logic                          fill_s4, err_s4;
	logic [tpsi_pkg::FILL_W-1:0]   word_s4;
	logic [tpsi_pkg::P3_W-1:0]     p3;

	// final multiply-add; the flat offset wraps to the output width
	assign p3 = tpsi_pkg::P3_W'(p2_s3) * tpsi_pkg::P3_W'(size_q[tpsi_pkg::DIM_WIDTH])
		+ tpsi_pkg::P3_W'(col_s3);

	always_ff @(posedge clk) begin
		if (coord.valid && rdy_s1) begin
			for (int i = 0; i < R; i++) begin
				idx_s1[i] <= map_a[i].idx;
			end
			fill_s1 <= |fill_v;
			err_s1  <= (|err_v) || (mode_q == tpsi_pkg::MODE_UNSUPPORTED);
		end
		if (v_s1 && rdy_s2) begin
			p1_s2 <= tpsi_pkg::P1_W'(idx_s1[tpsi_pkg::DIM_BATCH])
				* tpsi_pkg::P1_W'(size_q[tpsi_pkg::DIM_CHANNEL])
				+ tpsi_pkg::P1_W'(idx_s1[tpsi_pkg::DIM_CHANNEL]);
			row_s2  <= idx_s1[tpsi_pkg::DIM_HEIGHT];
			col_s2  <= idx_s1[tpsi_pkg::DIM_WIDTH];
			fill_s2 <= fill_s1;
			err_s2  <= err_s1;
		end
		if (v_s2 && rdy_s3) begin
			p2_s3 <= tpsi_pkg::P2_W'(p1_s2)
				* tpsi_pkg::P2_W'(size_q[tpsi_pkg::DIM_HEIGHT])
				+ tpsi_pkg::P2_W'(row_s2);
			col_s3  <= col_s2;
			fill_s3 <= fill_s2;
			err_s3  <= err_s2;
		end
		if (v_s3 && rdy_s4) begin
			// error wins over fill; both force the offset to zero
			offset_s4 <= (err_s3 || fill_s3) ? '0 : tpsi_pkg::OFFSET_W'(p3);
			fill_s4   <= fill_s3 && !err_s3;
			word_s4   <= (fill_s3 && !err_s3) ? fill_q : '0;
			err_s4    <= err_s3;
		end
	end

	assign addr.valid         = v_s4;
	assign addr.source_offset = offset_s4;
	assign addr.use_fill      = fill_s4;
	assign addr.fill_word     = word_s4;
	assign addr.index_error   = err_s4;

	// checks
	a_accept_fills_s1: assert property (@(posedge clk) disable iff (!arst_n)
		(coord.valid && coord.ready) |=> v_s1)
		else $error("accepted item did not reach stage 1");

	a_err_clears: assert property (@(posedge clk) disable iff (!arst_n)
		(addr.valid && addr.index_error) |->
			(addr.source_offset == '0 && !addr.use_fill && addr.fill_word == '0))
		else $error("error item carries nonzero fields");

	a_fill_clean: assert property (@(posedge clk) disable iff (!arst_n)
		(addr.valid && addr.use_fill) |->
			(!addr.index_error && addr.source_offset == '0))
		else $error("fill item carries offset or error");

	a_word_only_fill: assert property (@(posedge clk) disable iff (!arst_n)
		(addr.valid && !addr.use_fill) |-> (addr.fill_word == '0))
		else $error("fill word set without use_fill");

endmodule

// ----- tb/tensor_pad_source_index_tb.sv -----
// Testbench for tensor_pad_source_index: coordinate items in, address items out.
// Depends on tpsi_pkg, the tpsi_ifs interfaces and the RTL top level.
// An in-bench predictor keeps its own register copy and checks every item in order.
module tensor_pad_source_index_tb;
	timeunit 1ns;
	timeprecision 1ps;

	import tpsi_pkg::*;

	localparam int ITEM_TARGET = 1250;
	localparam int IDLE_LIMIT  = 2000;  // cycles with no handshake anywhere
	localparam int TAIL_CYCLES = 8;     // pipeline is 4 deep, doubled
	localparam int MAX_COORD   = (1 << COORD_W) - 1;

	// one address item as the block presents it
	typedef struct packed {
		logic [OFFSET_W-1:0] source_offset;
		logic                use_fill;
		logic [FILL_W-1:0]   fill_word;
		logic                index_error;
	} addr_item_t;

	// Tracks register state, predicts each address item, holds them in order.
	class pad_address_tracker;
		// mirror offsets: reflect skips the edge, symmetric repeats it
		localparam longint REFLECT_TAIL_ADJ   = -2;
		localparam longint SYMMETRIC_EDGE_ADJ = -1;

		pad_mode_t          mode;
		logic [FILL_W-1:0]  fill;
		logic [31:0]        geo [TENSOR_RANK];
		addr_item_t         pending_addrs [$];
		int                 errors;
		int                 checked;

		function new();
			mode = MODE_CONSTANT;
			fill = '0;
			foreach (geo[d]) geo[d] = 32'd1;
			errors  = 0;
			checked = 0;
		endfunction

		function void write_reg(logic [CFG_IDX_W-1:0] reg_idx, logic [CFG_DATA_W-1:0] data);
			case (reg_idx)
				REG_PAD_MODE:    mode = pad_mode_t'(data[1:0]);
				REG_FILL_BITS:   fill = data;
				REG_BATCH_GEO:   geo[DIM_BATCH] = data;
				REG_CHANNEL_GEO: geo[DIM_CHANNEL] = data;
				REG_HEIGHT_GEO:  geo[DIM_HEIGHT] = data;
				REG_WIDTH_GEO:   geo[DIM_WIDTH] = data;
				default: ;
			endcase
		endfunction

		// one padded-output coordinate to an input index along one dimension
		function void map_axis(logic [COORD_W-1:0] coord, logic [31:0] geo_word,
				output longint idx, output bit fill_hit, output bit in_range);
			longint size_v, pad_v, o, src, lead, past, lead_adj, tail_adj;
			size_v   = longint'(geo_word[DIM_BITS-1:0]);
			pad_v    = longint'(geo_word[GEO_PAD_LSB +: DIM_BITS]);
			o        = longint'(coord);
			fill_hit = 1'b0;
			in_range = 1'b1;
			if (mode == MODE_CONSTANT) begin
				src = o - pad_v;
				if (src < 0 || src >= size_v) begin
					fill_hit = 1'b1;
					src = 0;
				end
				idx = src;
				return;
			end
			lead_adj = (mode == MODE_REFLECT) ? 0 : SYMMETRIC_EDGE_ADJ;
			tail_adj = (mode == MODE_REFLECT) ? REFLECT_TAIL_ADJ : SYMMETRIC_EDGE_ADJ;
			lead = pad_v - o;
			if (lead > 0) begin
				src = lead + lead_adj;
			end else begin
				past = o - (size_v + pad_v);
				src = (past >= 0) ? size_v - past + tail_adj : -lead;
			end
			if (src < 0 || src >= size_v) begin
				in_range = 1'b0;
				src = 0;
			end
			idx = src;
		endfunction

		function addr_item_t address_for(logic [COORD_W-1:0] crd [TENSOR_RANK]);
			addr_item_t r;
			longint     idx [TENSOR_RANK];
			bit         hit, ok, any_fill, any_err;
			logic [63:0] offset;
			r = '0;
			if (mode == MODE_UNSUPPORTED) begin
				r.index_error = 1'b1;
				return r;
			end
			any_fill = 1'b0;
			any_err  = 1'b0;
			for (int d = 0; d < TENSOR_RANK; d++) begin
				map_axis(crd[d], geo[d], idx[d], hit, ok);
				any_fill |= hit;
				any_err  |= !ok;
			end
			if (any_err) begin
				r.index_error = 1'b1;
			end else if (any_fill) begin
				r.use_fill  = 1'b1;
				r.fill_word = fill;
			end else begin
				offset = '0;
				for (int d = 0; d < TENSOR_RANK; d++)
					offset = offset * 64'(geo[d][DIM_BITS-1:0]) + 64'(idx[d]);
				r.source_offset = offset[OFFSET_W-1:0];
			end
			return r;
		endfunction

		function void note_coord(logic [COORD_W-1:0] crd [TENSOR_RANK]);
			pending_addrs.push_back(address_for(crd));
		endfunction

		function int pending();
			return pending_addrs.size();
		endfunction

		task report(string what, logic [63:0] got, logic [63:0] want);
			$display("ERROR addr item %0d: %s got 0x%0h expected 0x%0h",
				checked, what, got, want);
			errors++;
		endtask

		task check_addr(addr_item_t got);
			addr_item_t want;
			if (pending_addrs.size() == 0) begin
				report("unexpected item, source_offset", 64'(got.source_offset), 64'hx);
				checked++;
				return;
			end
			want = pending_addrs.pop_front();
			if (got.source_offset !== want.source_offset)
				report("source_offset", 64'(got.source_offset), 64'(want.source_offset));
			if (got.use_fill !== want.use_fill)
				report("use_fill", 64'(got.use_fill), 64'(want.use_fill));
			if (got.fill_word !== want.fill_word)
				report("fill_word", 64'(got.fill_word), 64'(want.fill_word));
			if (got.index_error !== want.index_error)
				report("index_error", 64'(got.index_error), 64'(want.index_error));
			checked++;
		endtask
	endclass

	logic clk;
	logic arst_n;

	tpsi_coord_if coord_ch ();
	tpsi_addr_if  addr_ch ();
	tpsi_cfg_if   cfg_ch ();

	tensor_pad_source_index dut (
		.clk    (clk),
		.arst_n (arst_n),
		.coord  (coord_ch),
		.addr   (addr_ch),
		.cfg    (cfg_ch)
	);

	pad_address_tracker tracker = new();

	bit steady_src;    // sender never idles in this phase
	bit steady_sink;   // receiver never stalls in this phase
	int coords_sent;
	int idle_cycles;
	int stall_left;

	initial clk = 1'b0;
	always #5 clk = ~clk;

	// ---------------------------------------------------------------
	// Receiver: random stall drawn per item, check on every handshake
	// ---------------------------------------------------------------
	always @(posedge clk) begin
		if (!arst_n) begin
			addr_ch.ready <= 1'b0;
			stall_left = 0;
		end else if (addr_ch.valid && addr_ch.ready) begin
			tracker.check_addr('{addr_ch.source_offset, addr_ch.use_fill,
				addr_ch.fill_word, addr_ch.index_error});
			stall_left = steady_sink ? 0 : $urandom_range(0, 7);
			addr_ch.ready <= (stall_left == 0);
		end else if (!addr_ch.ready) begin
			if (stall_left > 0)
				stall_left--;
			if (stall_left == 0)
				addr_ch.ready <= 1'b1;
		end
	end

	// ---------------------------------------------------------------
	// Watchdog: too long without any handshake means a hang
	// ---------------------------------------------------------------
	always @(posedge clk) begin
		if (arst_n) begin
			if ((coord_ch.valid && coord_ch.ready) || (addr_ch.valid && addr_ch.ready) ||
					(cfg_ch.valid && cfg_ch.ready))
				idle_cycles = 0;
			else
				idle_cycles++;
			if (idle_cycles >= IDLE_LIMIT) begin
				$display("watchdog: no handshake for %0d cycles, %0d items outstanding",
					IDLE_LIMIT, tracker.pending());
				$display("DONE: errors detected");
				$finish;
			end
		end
	end

	// register write; the user must write only while idle, the block itself does not enforce it
	task automatic cfg_write(logic [CFG_IDX_W-1:0] reg_idx, logic [CFG_DATA_W-1:0] data);
		cfg_ch.valid <= 1'b1;
		cfg_ch.index <= reg_idx;
		cfg_ch.data  <= data;
		do @(posedge clk); while (!cfg_ch.ready);
		tracker.write_reg(reg_idx, data);
		cfg_ch.valid <= 1'b0;
		@(posedge clk);
	endtask

	// stop sending and hold off until every predicted item has come back
	task automatic drain();
		coord_ch.valid <= 1'b0;
		while (tracker.pending() != 0)
			@(posedge clk);
	endtask

	task automatic reconfigure(pad_mode_t mode, logic [FILL_W-1:0] fill_v,
			logic [31:0] g_batch, logic [31:0] g_chan, logic [31:0] g_row,
			logic [31:0] g_col);
		logic [31:0] mode_word;
		drain();
		// upper bits of the mode word are don't-care; scramble them
		mode_word = ($urandom & ~32'h3) | 32'(mode);
		cfg_write(REG_PAD_MODE, mode_word);
		cfg_write(REG_FILL_BITS, fill_v);
		cfg_write(REG_BATCH_GEO, g_batch);
		cfg_write(REG_CHANNEL_GEO, g_chan);
		cfg_write(REG_HEIGHT_GEO, g_row);
		cfg_write(REG_WIDTH_GEO, g_col);
	endtask

	// one coordinate item; valid stays up across back-to-back items
	task automatic send_coord(int b, int c, int h, int w);
		logic [COORD_W-1:0] crd [TENSOR_RANK];
		int gap;
		crd[DIM_BATCH]   = COORD_W'(b);
		crd[DIM_CHANNEL] = COORD_W'(c);
		crd[DIM_HEIGHT]  = COORD_W'(h);
		crd[DIM_WIDTH]   = COORD_W'(w);
		gap = steady_src ? 0 : $urandom_range(0, 7);
		if (gap != 0) begin
			coord_ch.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		coord_ch.valid       <= 1'b1;
		coord_ch.out_batch   <= crd[DIM_BATCH];
		coord_ch.out_channel <= crd[DIM_CHANNEL];
		coord_ch.out_row     <= crd[DIM_HEIGHT];
		coord_ch.out_column  <= crd[DIM_WIDTH];
		do @(posedge clk); while (!coord_ch.ready);
		tracker.note_coord(crd);
		coords_sent++;
	endtask

	// Random phase: pick mode and geometry, then walk mostly inside the
	// padded output (pad + size + up to size more), with a tenth of the
	// coordinates as raw 13-bit noise to hit the far end and every bit.
	task automatic random_phase();
		logic [31:0] geo_word [TENSOR_RANK];
		int          size_eff [TENSOR_RANK];
		int          pad_eff [TENSOR_RANK];
		int          crd [TENSOR_RANK];
		int          pick, sz, span, n_items;
		pad_mode_t   mode;
		pick = $urandom_range(0, 9);
		mode = (pick < 3) ? MODE_CONSTANT : (pick < 6) ? MODE_REFLECT :
			(pick < 9) ? MODE_SYMMETRIC : MODE_UNSUPPORTED;
		for (int d = 0; d < TENSOR_RANK; d++) begin
			pick = $urandom_range(0, 9);
			if (pick == 0) begin
				geo_word[d] = $urandom;
			end else if (pick == 1) begin
				// degenerate or full-size dimension
				sz = $urandom_range(0, 1) ? (1 << DIM_BITS) - 1 : 0;
				geo_word[d] = {4'h0, 12'($urandom_range(0, 4095)), 4'h0, 12'(sz)};
			end else begin
				sz = $urandom_range(1, 6);
				geo_word[d] = {4'h0, 12'($urandom_range(0, sz)), 4'h0, 12'(sz)};
			end
			// ignored high nibbles still get toggled now and then
			if ($urandom_range(0, 3) == 0) begin
				geo_word[d][15:12] = 4'($urandom);
				geo_word[d][31:28] = 4'($urandom);
			end
			size_eff[d] = int'(geo_word[d][DIM_BITS-1:0]);
			pad_eff[d]  = int'(geo_word[d][GEO_PAD_LSB +: DIM_BITS]);
		end
		reconfigure(mode, $urandom, geo_word[DIM_BATCH], geo_word[DIM_CHANNEL],
			geo_word[DIM_HEIGHT], geo_word[DIM_WIDTH]);
		steady_src  = ($urandom_range(0, 3) == 0);
		steady_sink = ($urandom_range(0, 3) == 0);
		n_items = $urandom_range(20, 80);
		repeat (n_items) begin
			for (int d = 0; d < TENSOR_RANK; d++) begin
				if ($urandom_range(0, 9) == 0) begin
					crd[d] = $urandom_range(0, MAX_COORD);
				end else begin
					span = pad_eff[d] + 2 * size_eff[d];
					if (span > MAX_COORD)
						span = MAX_COORD;
					crd[d] = $urandom_range(0, span);
				end
			end
			send_coord(crd[DIM_BATCH], crd[DIM_CHANNEL], crd[DIM_HEIGHT], crd[DIM_WIDTH]);
		end
	endtask

	// ---------------------------------------------------------------
	// Main sequence
	// ---------------------------------------------------------------
	initial begin
		arst_n               = 1'b0;
		coord_ch.valid       = 1'b0;
		coord_ch.out_batch   = '0;
		coord_ch.out_channel = '0;
		coord_ch.out_row     = '0;
		coord_ch.out_column  = '0;
		cfg_ch.valid         = 1'b0;
		cfg_ch.index         = '0;
		cfg_ch.data          = '0;
		addr_ch.ready        = 1'b0;
		steady_src           = 1'b0;
		steady_sink          = 1'b0;
		coords_sent          = 0;
		idle_cycles          = 0;
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// reset geometry: every dimension size 1, no padding, constant mode
		send_coord(0, 0, 0, 0);
		send_coord(MAX_COORD, MAX_COORD, MAX_COORD, MAX_COORD);   // fill, word 0

		// small odd geometry: N=2 pad1, C=3 pad2, H=4 pad0, W=5 pad3
		reconfigure(MODE_CONSTANT, 32'hFFFF_FFFF, 32'h0001_0002, 32'h0002_0003,
			32'h0000_0004, 32'h0003_0005);
		send_coord(1, 2, 0, 3);       // first input element
		send_coord(2, 4, 3, 7);       // last input element
		send_coord(0, 2, 0, 3);       // in leading batch padding
		send_coord(3, 2, 0, 3);       // past the batch end

		// reflect: leading mirror, trailing mirror, and a tail out of range
		reconfigure(MODE_REFLECT, 32'hFFFF_FFFF, 32'h0001_0002, 32'h0002_0003,
			32'h0000_0004, 32'h0003_0005);
		send_coord(0, 0, 0, 0);
		send_coord(3, 5, 5, 9);
		send_coord(4, 0, 0, 0);

		// symmetric: edge repeated on both sides, far coordinate errors out
		reconfigure(MODE_SYMMETRIC, 32'hFFFF_FFFF, 32'h0001_0002, 32'h0002_0003,
			32'h0000_0004, 32'h0003_0005);
		send_coord(0, 0, 0, 0);
		send_coord(3, 5, 7, 10);
		send_coord(0, 0, 0, MAX_COORD);

		// unsupported mode flags regardless of coordinate
		reconfigure(MODE_UNSUPPORTED, 32'hA5A5_5A5A, 32'h0001_0002, 32'h0002_0003,
			32'h0000_0004, 32'h0003_0005);
		send_coord(1, 2, 0, 3);

		// largest geometry; junk in the ignored high nibbles
		reconfigure(MODE_CONSTANT, 32'h0000_0000, 32'hFFFF_FFFF, 32'hFFFF_FFFF,
			32'hFFFF_FFFF, 32'hFFFF_FFFF);
		send_coord(4095, 4095, 4095, 4095);   // offset 0
		send_coord(8189, 8189, 8189, 8189);   // largest offset
		send_coord(8190, 8190, 8190, 8190);   // just past the end
		send_coord(0, 0, 0, 0);
		reconfigure(MODE_SYMMETRIC, 32'h8000_0001, 32'hFFFF_FFFF, 32'hFFFF_FFFF,
			32'hFFFF_FFFF, 32'hFFFF_FFFF);
		send_coord(0, 0, 0, 0);
		send_coord(MAX_COORD, MAX_COORD, MAX_COORD, MAX_COORD);

		// zero-size width: fill in constant mode, error when mirrored
		reconfigure(MODE_CONSTANT, 32'h1234_5678, 32'h0000_0001, 32'h0000_0001,
			32'h0000_0001, 32'h0000_0000);
		send_coord(0, 0, 0, 0);
		reconfigure(MODE_REFLECT, 32'h1234_5678, 32'h0000_0001, 32'h0000_0001,
			32'h0000_0001, 32'h0000_0000);
		send_coord(0, 0, 0, 0);
		// reflect with padding as large as the size overruns the input
		reconfigure(MODE_REFLECT, 32'h1234_5678, 32'h0000_0001, 32'h0000_0001,
			32'h0000_0001, 32'h0005_0005);
		send_coord(0, 0, 0, 0);

		while (coords_sent < ITEM_TARGET)
			random_phase();

		drain();
		repeat (TAIL_CYCLES) @(posedge clk);
		if (tracker.errors == 0 && tracker.pending() == 0)
			$display("DONE: 0 errors");
		else
			$display("DONE: errors detected");
		$finish;
	end
endmodule
